### design/m2q_pkg.sv
package m2q_pkg;

   // Q1.14 unity
   localparam int ONE_Q14 = 16384;
   // Clamped diagonal sum is at most 1 + 3 * 2 (Q.14), fits 18 bits unsigned
   localparam int SUM_W = 18;
   // Radicand is sum * 4096: 30 bits, root is 15 bits
   localparam int RAD_W = 30;
   localparam int ROOT_W = 15;
   // One root bit per cell
   localparam int CELLS = ROOT_W;
   // Working remainder width for the digit recurrence
   localparam int REM_W = ROOT_W + 2;

   typedef logic signed [15:0] q14_type;

   // Everything one square-root lane carries from cell to cell
   typedef struct packed {
      logic [RAD_W-1:0] rad;
      logic [REM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } lane_type;

   // Data that rides along the cell chain beside the four lanes
   typedef struct packed {
      logic valid;
      logic neg_x;
      logic neg_y;
      logic neg_z;
   } side_type;

endpackage

### design/matrix_to_quaternion_copysign.sv
// Channel | Direction | Ports
// req     | in        | req_valid, req_ready, req_right_x .. req_at_z (9 x 16b signed)
// rsp     | out       | rsp_valid, rsp_ready, rsp_quat_w (15b), rsp_quat_x/y/z (16b signed)
//
// One word is accepted per cycle while rsp is not stalled. The pipeline is
// one input stage forming the diagonal sums, fifteen root cells (one result
// bit each), and the output register. Reset clears only the valid bits. A
// stalled rsp side freezes the whole chain, so req_ready falls whenever the
// output word is held, whether or not the stages in front of it carry words.
module matrix_to_quaternion_copysign (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  m2q_pkg::q14_type req_right_x,
   input  m2q_pkg::q14_type req_right_y,
   input  m2q_pkg::q14_type req_right_z,
   input  m2q_pkg::q14_type req_up_x,
   input  m2q_pkg::q14_type req_up_y,
   input  m2q_pkg::q14_type req_up_z,
   input  m2q_pkg::q14_type req_at_x,
   input  m2q_pkg::q14_type req_at_y,
   input  m2q_pkg::q14_type req_at_z,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [14:0] rsp_quat_w,
   output m2q_pkg::q14_type rsp_quat_x,
   output m2q_pkg::q14_type rsp_quat_y,
   output m2q_pkg::q14_type rsp_quat_z
);
   import m2q_pkg::*;

   lane_type lane_s [CELLS+1][4];
   side_type side_s [CELLS+1];
   lane_type lane0_ff [4];
   lane_type lane0_in [4];
   side_type side0_ff;
   side_type side0_in;
   logic advance;
   logic rsp_valid_ff;
   logic [14:0] quat_w_ff;
   q14_type quat_x_ff, quat_y_ff, quat_z_ff;

   // Move when the output register is free or being emptied
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Form clamped diagonal sums and sign bits
   always_comb begin
      logic signed [18:0] s [4];
      logic signed [16:0] dx, dy, dz;
      s[0] = 19'(ONE_Q14) + 19'(req_right_x) + 19'(req_up_y) + 19'(req_at_z);
      s[1] = 19'(ONE_Q14) + 19'(req_right_x) - 19'(req_up_y) - 19'(req_at_z);
      s[2] = 19'(ONE_Q14) - 19'(req_right_x) + 19'(req_up_y) - 19'(req_at_z);
      s[3] = 19'(ONE_Q14) - 19'(req_right_x) - 19'(req_up_y) + 19'(req_at_z);
      for (int l = 0; l < 4; l++) begin
         lane0_in[l].rad  = s[l][18] ? '0 : {s[l][SUM_W-1:0], 12'd0};
         lane0_in[l].rem  = '0;
         lane0_in[l].root = '0;
      end
      dx = 17'(req_at_y) - 17'(req_up_z);
      dy = 17'(req_right_z) - 17'(req_at_x);
      dz = 17'(req_up_x) - 17'(req_right_y);
      side0_in.valid = req_valid;
      side0_in.neg_x = dx[16];
      side0_in.neg_y = dy[16];
      side0_in.neg_z = dz[16];
   end

   // Register the input word
   always_ff @(posedge clock) begin
      if (reset) begin
         side0_ff.valid <= 1'b0;
      end else if (advance) begin
         side0_ff.valid <= side0_in.valid;
      end
      if (advance) begin
         lane0_ff       <= lane0_in;
         side0_ff.neg_x <= side0_in.neg_x;
         side0_ff.neg_y <= side0_in.neg_y;
         side0_ff.neg_z <= side0_in.neg_z;
      end
   end

   assign lane_s[0] = lane0_ff;
   assign side_s[0] = side0_ff;

   // Chain of root cells
   for (genvar c = 0; c < CELLS; c++) begin : g_cell
      m2q_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .advance(advance),
         .lane_i (lane_s[c]),
         .side_i (side_s[c]),
         .lane_o (lane_s[c+1]),
         .side_o (side_s[c+1])
      );
   end

   // Apply signs and hold the output word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= side_s[CELLS].valid;
      end
      if (advance) begin
         quat_w_ff <= lane_s[CELLS][0].root;
         quat_x_ff <= side_s[CELLS].neg_x ? -q14_type'({1'b0, lane_s[CELLS][1].root})
                                          : q14_type'({1'b0, lane_s[CELLS][1].root});
         quat_y_ff <= side_s[CELLS].neg_y ? -q14_type'({1'b0, lane_s[CELLS][2].root})
                                          : q14_type'({1'b0, lane_s[CELLS][2].root});
         quat_z_ff <= side_s[CELLS].neg_z ? -q14_type'({1'b0, lane_s[CELLS][3].root})
                                          : q14_type'({1'b0, lane_s[CELLS][3].root});
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_w = quat_w_ff;
   assign rsp_quat_x = quat_x_ff;
   assign rsp_quat_y = quat_y_ff;
   assign rsp_quat_z = quat_z_ff;

endmodule

### design/m2q_cell.sv
module m2q_cell (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  m2q_pkg::lane_type lane_i [4],
   input  m2q_pkg::side_type side_i,
   output m2q_pkg::lane_type lane_o [4],
   output m2q_pkg::side_type side_o
);
   import m2q_pkg::*;

   lane_type lane_ff [4];
   lane_type lane_in [4];
   side_type side_ff;

   // Produce one root bit per lane: bring down two radicand bits, trial subtract
   always_comb begin
      logic [REM_W-1:0] cur;
      logic [REM_W-1:0] trial;
      for (int l = 0; l < 4; l++) begin
         cur   = {lane_i[l].rem[REM_W-3:0], lane_i[l].rad[RAD_W-1 -: 2]};
         trial = {lane_i[l].root, 2'b01};
         lane_in[l].rad = {lane_i[l].rad[RAD_W-3:0], 2'b00};
         if (cur >= trial) begin
            lane_in[l].rem  = cur - trial;
            lane_in[l].root = {lane_i[l].root[ROOT_W-2:0], 1'b1};
         end else begin
            lane_in[l].rem  = cur;
            lane_in[l].root = {lane_i[l].root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Hold while the chain is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (advance) begin
         side_ff.valid <= side_i.valid;
      end
      if (advance) begin
         lane_ff         <= lane_in;
         side_ff.neg_x   <= side_i.neg_x;
         side_ff.neg_y   <= side_i.neg_y;
         side_ff.neg_z   <= side_i.neg_z;
      end
   end

   assign lane_o = lane_ff;
   assign side_o = side_ff;

endmodule

### design/m2q_checker.sv
module m2q_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [14:0] rsp_quat_w,
   input logic [15:0] rsp_quat_x
);

   // Output word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quat_w) && $stable(rsp_quat_x))
      else $error("rsp word changed while stalled");

   // Ready follows the output side
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

   // Magnitude never exceeds the largest possible root
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quat_w <= 15'd21674)
      else $error("quat_w out of range");

   // Nothing comes out after reset without input
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind matrix_to_quaternion_copysign m2q_checker u_m2q_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_quat_w(rsp_quat_w),
   .rsp_quat_x(rsp_quat_x)
);

### verif/m2q_checker.sv
module m2q_scoreboard (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  m2q_pkg::q14_type req_right_x,
   input  m2q_pkg::q14_type req_right_y,
   input  m2q_pkg::q14_type req_right_z,
   input  m2q_pkg::q14_type req_up_x,
   input  m2q_pkg::q14_type req_up_y,
   input  m2q_pkg::q14_type req_up_z,
   input  m2q_pkg::q14_type req_at_x,
   input  m2q_pkg::q14_type req_at_y,
   input  m2q_pkg::q14_type req_at_z,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic [14:0] rsp_quat_w,
   input  m2q_pkg::q14_type rsp_quat_x,
   input  m2q_pkg::q14_type rsp_quat_y,
   input  m2q_pkg::q14_type rsp_quat_z,
   output int errors,
   output int pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [14:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   quat_type quat_q[$];

   // floor(sqrt(s * 4096)) of a clamped sum, by bitwise search
   function automatic int half_root(int s);
      longint rad;
      longint root;
      if (s <= 0) return 0;
      rad = longint'(s) * 4096;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         if ((root + (longint'(1) << b)) * (root + (longint'(1) << b)) <= rad)
            root += longint'(1) << b;
      end
      if (root > 32767) root = 32767;
      return int'(root);
   endfunction

   function automatic logic signed [15:0] apply_sign(int mag, int diff);
      int v;
      v = (diff < 0) ? -mag : mag;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   function automatic quat_type matrix_to_quat();
      int rx, ry, rz, ux, uy, uz, ax, ay, az;
      quat_type q;
      rx = req_right_x; ry = req_right_y; rz = req_right_z;
      ux = req_up_x; uy = req_up_y; uz = req_up_z;
      ax = req_at_x; ay = req_at_y; az = req_at_z;
      q.w = 15'(half_root(m2q_pkg::ONE_Q14 + rx + uy + az));
      q.x = apply_sign(half_root(m2q_pkg::ONE_Q14 + rx - uy - az), ay - uz);
      q.y = apply_sign(half_root(m2q_pkg::ONE_Q14 - rx + uy - az), rz - ax);
      q.z = apply_sign(half_root(m2q_pkg::ONE_Q14 - rx - uy + az), ux - ry);
      return q;
   endfunction

   // predict on each accepted input word, compare on each output word
   always @(posedge clock) begin
      quat_type want;
      if (!reset) begin
         if (req_valid && req_ready) quat_q.push_back(matrix_to_quat());
         if (rsp_valid && rsp_ready) begin
            if (quat_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected word w=%0d x=%0d y=%0d z=%0d",
                  rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
            end else begin
               want = quat_q.pop_front();
               if (want.w !== rsp_quat_w || want.x !== rsp_quat_x ||
                   want.y !== rsp_quat_y || want.z !== rsp_quat_z) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch exp w=%0d x=%0d y=%0d z=%0d got %0d %0d %0d %0d",
                        want.w, want.x, want.y, want.z,
                        rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
               end
            end
         end
      end
      pending = quat_q.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end
endmodule

### verif/tb_matrix_to_quaternion_copysign.sv
module tb_matrix_to_quaternion_copysign;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   m2q_pkg::q14_type elem [9];
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [14:0] rsp_quat_w;
   m2q_pkg::q14_type rsp_quat_x, rsp_quat_y, rsp_quat_z;
   int errors, pending;
   int send_idle = 0;
   int recv_stall = 0;
   int hold_off = 0;

   always #1 clock = ~clock;

   initial foreach (elem[i]) elem[i] = '0;

   matrix_to_quaternion_copysign uut (
      .clock, .reset, .req_valid, .req_ready,
      .req_right_x(elem[0]), .req_right_y(elem[1]), .req_right_z(elem[2]),
      .req_up_x(elem[3]), .req_up_y(elem[4]), .req_up_z(elem[5]),
      .req_at_x(elem[6]), .req_at_y(elem[7]), .req_at_z(elem[8]),
      .rsp_valid, .rsp_ready, .rsp_quat_w, .rsp_quat_x, .rsp_quat_y, .rsp_quat_z);

   m2q_scoreboard chk (
      .clock, .reset, .req_valid, .req_ready,
      .req_right_x(elem[0]), .req_right_y(elem[1]), .req_right_z(elem[2]),
      .req_up_x(elem[3]), .req_up_y(elem[4]), .req_up_z(elem[5]),
      .req_at_x(elem[6]), .req_at_y(elem[7]), .req_at_z(elem[8]),
      .rsp_valid, .rsp_ready, .rsp_quat_w, .rsp_quat_x, .rsp_quat_y, .rsp_quat_z,
      .errors, .pending);

   // receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // offer one word and hold it until accepted
   task automatic send_word(input logic [15:0] m [9]);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      for (int i = 0; i < 9; i++) elem[i] <= m[i];
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until every expected result is back
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // random words: some with near +-1.0 diagonals, some symmetric, others unconstrained
   task automatic send_random();
      logic [15:0] m [9];
      int kind;
      kind = $urandom_range(9);
      foreach (m[i]) m[i] = 16'($urandom);
      if (kind < 6) begin
         foreach (m[i]) m[i] = 16'($signed($urandom_range(32768)) - 16384);
         if (kind < 2) begin
            m[0] = 16'(($urandom_range(1) ? 16384 : -16384) + $urandom_range(64) - 32);
            m[4] = 16'(($urandom_range(1) ? 16384 : -16384) + $urandom_range(64) - 32);
            m[8] = 16'(($urandom_range(1) ? 16384 : -16384) + $urandom_range(64) - 32);
         end
      end else if (kind == 6) begin
         m[5] = m[7]; m[6] = m[2]; m[1] = m[3];
      end
      send_word(m);
   endtask

   initial begin
      logic [15:0] m [9];
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: identity, 180- and 90-degree turns, extremes, zero differences
      m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_word(m);
      m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_word(m);
      m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_word(m);
      m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_word(m);
      m = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
            16'h7fff, 16'h7fff, 16'h7fff}; send_word(m);
      m = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 16'h8000, 16'h8000}; send_word(m);
      m = '{16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
            16'h8000, 16'h7fff, 16'h8000}; send_word(m);
      m = '{16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
            16'h7fff, 16'h8000, 16'h7fff}; send_word(m);
      m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_word(m);
      m = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
            16'hffff, 16'hffff, 16'hffff}; send_word(m);
      m = '{0, 16384, 0, -16384, 0, 0, 0, 0, 16384}; send_word(m);
      m = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}; send_word(m);
      m = '{16'h7fff, 0, 0, 0, 16'h7fff, 0, 0, 0, 16'h7fff}; send_word(m);
      m = '{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000}; send_word(m);

      // random phases: no idling, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1) ? 59 : (ph == 3) ? 28 : 0;
         recv_stall = (ph == 2) ? 59 : (ph == 3) ? 28 : 0;
         if (ph == 2) hold_off = 60;
         repeat (134) send_random();
         // pause until all results are back
         drain();
      end

      drain();
      repeat (40) @(posedge clock);
      if (errors == 0 && pending == 0) $display("tb_matrix_to_quaternion_copysign: clean");
      else $display("tb_matrix_to_quaternion_copysign: errors");
      $finish;
   end

   initial begin
      #200000;
      $display("tb_matrix_to_quaternion_copysign: errors");
      $finish;
   end
endmodule

### files.f
design/m2q_pkg.sv
design/m2q_cell.sv
design/matrix_to_quaternion_copysign.sv
design/m2q_checker.sv
verif/m2q_checker.sv
verif/tb_matrix_to_quaternion_copysign.sv
